[design/refcounted_frame_buffer_pool_assert.svh]
`ifndef REFCOUNTED_FRAME_BUFFER_POOL_ASSERT_SVH
`define REFCOUNTED_FRAME_BUFFER_POOL_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define RFBP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rfbp assertion failed");

// next-cycle implication, checked while out of reset
`define RFBP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rfbp assertion failed");

`endif

[design/rfbp_pkg.sv]
package rfbp_pkg;

  localparam int PoolFrames = 8;
  localparam int IdxW       = 3;
  localparam int TotalW     = 4;
  localparam int CountW     = 8;
  localparam int FrameBytes = 1048576;
  // must stay a power of two: the base is aligned by masking
  localparam int FrameAlign = 64;
  localparam longint FrameSlotL =
      ((longint'(FrameBytes) + FrameAlign - 1) / FrameAlign) * FrameAlign;
  localparam logic [31:0] FrameSlot  = FrameSlotL[31:0];
  localparam logic [31:0] AlignMask  = ~(32'(FrameAlign) - 32'd1);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADDREF  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_REINIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_EMPTY      = 2'd1,
    ERR_NOT_IN_USE = 2'd2,
    ERR_OVERFLOW   = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    REG_BUFFER_BASE  = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_LINE_STRIDE  = 3'd3,
    REG_PIXEL_FORMAT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] buffer_base;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] line_stride;
    logic [7:0]  pixel_format;
  } cfg_t;

  typedef struct packed {
    op_e            op;
    logic [IdxW-1:0] idx;
  } item_t;

  typedef struct packed {
    logic              granted;
    logic [IdxW-1:0]   frame_number;
    logic [31:0]       frame_address;
    logic [15:0]       frame_width;
    logic [15:0]       frame_height;
    logic [31:0]       frame_stride;
    logic [7:0]        frame_format;
    logic [TotalW-1:0] free_frames;
    err_e              error_code;
  } result_t;

endpackage

[design/rfbp_cfg_regs.sv]
module rfbp_cfg_regs import rfbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_BUFFER_BASE:  cfg_d.buffer_base  = pwdata;
        REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[15:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[15:0];
        REG_LINE_STRIDE:  cfg_d.line_stride  = pwdata;
        REG_PIXEL_FORMAT: cfg_d.pixel_format = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_BUFFER_BASE:  prdata = cfg_q.buffer_base;
      REG_IMAGE_WIDTH:  prdata = {16'd0, cfg_q.image_width};
      REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_q.image_height};
      REG_LINE_STRIDE:  prdata = cfg_q.line_stride;
      REG_PIXEL_FORMAT: prdata = {24'd0, cfg_q.pixel_format};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/rfbp_core.sv]
module rfbp_core import rfbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [IdxW-1:0]   stack_q [PoolFrames];
  logic [IdxW-1:0]   stack_d [PoolFrames];
  logic [CountW-1:0] cnt_q   [PoolFrames];
  logic [CountW-1:0] cnt_d   [PoolFrames];
  logic [TotalW-1:0] total_q, total_d;

  logic [IdxW-1:0]   top_ptr;
  logic [CountW-1:0] cnt_sel;
  logic              idx_ok;
  logic              addr_en;
  logic [IdxW-1:0]   number;
  logic              granted;
  err_e              err;

  assign top_ptr = IdxW'(total_q - TotalW'(1));
  assign cnt_sel = cnt_q[item_i.idx];
  assign idx_ok  = (TotalW'(item_i.idx) < TotalW'(PoolFrames));

  always_comb begin
    stack_d = stack_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    number  = '0;
    granted = 1'b0;
    addr_en = 1'b0;
    err     = ERR_NONE;
    unique case (item_i.op)
      OP_ALLOC: begin
        if (total_q == '0) begin
          err = ERR_EMPTY;
        end else begin
          total_d        = total_q - TotalW'(1);
          number         = stack_q[top_ptr];
          cnt_d[number]  = CountW'(1);
          granted        = 1'b1;
          addr_en        = 1'b1;
        end
      end
      OP_ADDREF: begin
        number  = item_i.idx;
        addr_en = 1'b1;
        if (!idx_ok || cnt_sel == '0) begin
          err = ERR_NOT_IN_USE;
        end else if (cnt_sel == CountMax) begin
          err = ERR_OVERFLOW;
        end else begin
          cnt_d[item_i.idx] = cnt_sel + CountW'(1);
        end
      end
      OP_RELEASE: begin
        number  = item_i.idx;
        addr_en = 1'b1;
        if (!idx_ok || cnt_sel == '0) begin
          err = ERR_NOT_IN_USE;
        end else begin
          cnt_d[item_i.idx] = cnt_sel - CountW'(1);
          // last reference gone: frame goes back on top of the free stack
          if (cnt_sel == CountW'(1) && total_q < TotalW'(PoolFrames)) begin
            stack_d[total_q[IdxW-1:0]] = item_i.idx;
            total_d = total_q + TotalW'(1);
          end
        end
      end
      OP_REINIT: begin
        for (int i = 0; i < PoolFrames; i++) begin
          stack_d[i] = IdxW'(i);
          cnt_d[i]   = '0;
        end
        total_d = TotalW'(PoolFrames);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.granted       = granted;
    res_o.frame_number  = number;
    res_o.frame_address = addr_en ?
        (cfg_i.buffer_base & AlignMask) + 32'(number) * FrameSlot : 32'd0;
    res_o.frame_width   = cfg_i.image_width;
    res_o.frame_height  = cfg_i.image_height;
    res_o.frame_stride  = cfg_i.line_stride;
    res_o.frame_format  = cfg_i.pixel_format;
    res_o.free_frames   = total_d;
    res_o.error_code    = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PoolFrames; i++) begin
        stack_q[i] <= IdxW'(i);
        cnt_q[i]   <= '0;
      end
      total_q <= TotalW'(PoolFrames);
    end else if (fire_i) begin
      stack_q <= stack_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

endmodule

[design/refcounted_frame_buffer_pool.sv]
// Pipeline: 2 register stages (input, result); an item moves on when the result register is
// empty or accepted. Throughput: one item per cycle while the output is not stalled; the pool
// state (free stack, counts) is updated in the same cycle the item moves to the result register.
// Reset (rst_ni low, async): config registers to 0, free stack 0..7 with 7 on
// top, all reference counts 0, both pipeline registers empty.
module refcounted_frame_buffer_pool import rfbp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [2:0] frame_index
  input  logic [1:0]   s_axis_tuser_i,   // [1:0] opcode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [2:0] frame_number, [34:3] frame_address, [50:35] frame_width,
  // [66:51] frame_height, [98:67] frame_stride, [106:99] frame_format,
  // [110:107] free_frames, [112:111] error_code
  output logic [119:0] m_axis_tdata_o,
  output logic [0:0]   m_axis_tuser_o,   // [0] granted
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res, out_q;
  logic    out_valid_q;
  logic    advance, fire, in_xfer;

  rfbp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  rfbp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.op  <= op_e'(s_axis_tuser_i);
      in_item_q.idx <= s_axis_tdata_i[IdxW-1:0];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.granted;
  assign m_axis_tdata_o  = {7'd0, out_q.error_code, out_q.free_frames,
                            out_q.frame_format, out_q.frame_stride,
                            out_q.frame_height, out_q.frame_width,
                            out_q.frame_address, out_q.frame_number};

endmodule

[design/rfbp_checker.sv]
`include "refcounted_frame_buffer_pool_assert.svh"

module rfbp_checker import rfbp_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid_i,
  input logic         m_tready_i,
  input logic [119:0] m_tdata_i,
  input logic [0:0]   m_tuser_i
);

  logic [IdxW-1:0]   number;
  logic [TotalW-1:0] free_frames;
  logic [1:0]        err;
  logic              grant_out;
  logic              pool_full;
  logic              empty_err;
  logic              empty_clean;
  logic              out_stall;

  assign number      = m_tdata_i[2:0];
  assign free_frames = m_tdata_i[110:107];
  assign err         = m_tdata_i[112:111];
  assign grant_out   = m_tvalid_i && m_tuser_i[0];
  assign pool_full   = (free_frames == TotalW'(PoolFrames));
  assign empty_err   = m_tvalid_i && (err == ERR_EMPTY);
  assign empty_clean = (free_frames == '0) && (number == '0) && !m_tuser_i[0];
  assign out_stall   = m_tvalid_i && !m_tready_i;

  `RFBP_ASSERT_IMP(a_free_bound, clk_i, rst_ni, m_tvalid_i, free_frames <= TotalW'(PoolFrames))

  // a grant pops a frame, so the pool cannot still be full, and no error goes with it
  `RFBP_ASSERT_IMP(a_grant_clean, clk_i, rst_ni, grant_out, err == ERR_NONE && !pool_full)

  `RFBP_ASSERT_IMP(a_empty_result, clk_i, rst_ni, empty_err, empty_clean)

  `RFBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_tvalid_i && $stable({m_tuser_i, m_tdata_i}))

endmodule

bind refcounted_frame_buffer_pool rfbp_checker u_rfbp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);
